// ----- rtl/pixel_block_upscaler_with_clip_assert.svh -----
// Assertion macros of the upscaler RTL, included by the top level.
`ifndef PIXEL_BLOCK_UPSCALER_WITH_CLIP_ASSERT_SVH
`define PIXEL_BLOCK_UPSCALER_WITH_CLIP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked outside reset.
`define PBU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("upscaler check failed");
// Checked at every edge, reset included.
`define PBU_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("upscaler check failed");
`else
`define PBU_ASSERT(lbl, prop)
`define PBU_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- rtl/pbu_pkg.sv -----
// Shared constants, register codes and helpers of the upscaler.
package pbu_pkg;

  localparam int DEF_MAX_SCALE  = 4;
  localparam int DEF_COORD_BITS = 12;

  // Width of the scale register and of the clamped replication factor.
  localparam int SCALE_BITS = 3;
  localparam int SCALE_W    = 4;

  localparam int CFG_ADDR_BITS = 2;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_SCALE   = 2'd0,
    REG_PANEL_W = 2'd1,
    REG_PANEL_H = 2'd2
  } cfg_reg_t;

  localparam logic [SCALE_BITS-1:0] RST_SCALE = 3'd2;
  localparam int RST_PANEL_W = 720;
  localparam int RST_PANEL_H = 1280;

  // Clamp the programmed scale: zero acts as one, anything above the max as the max.
  function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_BITS-1:0] s,
                                                     input logic [SCALE_W-1:0] max_s);
    logic [SCALE_W-1:0] s_ext;
    s_ext = SCALE_W'(s);
    if (s_ext == '0) begin
      return SCALE_W'(1);
    end else if (s_ext > max_s) begin
      return max_s;
    end else begin
      return s_ext;
    end
  endfunction

endpackage

// ----- rtl/pbu_pos.sv -----
// Input register and tile position counters of the upscaler.
module pbu_pos #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] tile_x,
  input  logic [COORD_BITS-1:0] tile_y,
  input  logic [COORD_BITS-1:0] tile_w,
  input  logic [COORD_BITS-1:0] tile_h,
  input  logic [15:0]           pixel,
  input  logic                  job_take,
  output logic                  job_valid,
  output logic [COORD_BITS:0]   job_lx,
  output logic [COORD_BITS:0]   job_ly,
  output logic [15:0]           job_color
);

  logic [COORD_BITS-1:0] column_pos, column_pos_next;
  logic [COORD_BITS-1:0] row_pos, row_pos_next;
  logic [COORD_BITS-1:0] col_inc, row_inc;
  logic                  accept;
  logic                  usable;

  assign in_stall = job_valid && !job_take;
  assign accept   = in_valid && !in_stall;
  assign usable   = (tile_w != '0) && (tile_h != '0);

  // Advance column; wrap to the next row, and wrap the row after the tile's end.
  always_comb begin
    col_inc = column_pos + COORD_BITS'(1);
    row_inc = row_pos + COORD_BITS'(1);
    column_pos_next = col_inc;
    row_pos_next    = row_pos;
    if (col_inc >= tile_w) begin
      column_pos_next = '0;
      row_pos_next    = (row_inc >= tile_h) ? '0 : row_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos    <= '0;
      job_valid  <= 1'b0;
    end else begin
      if (accept && usable) begin
        column_pos <= column_pos_next;
        row_pos    <= row_pos_next;
        job_valid  <= 1'b1;
      end else if (job_take) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && usable) begin
      job_lx    <= {1'b0, tile_x} + {1'b0, column_pos};
      job_ly    <= {1'b0, tile_y} + {1'b0, row_pos};
      job_color <= pixel;
    end
  end

endmodule

// ----- rtl/pbu_gen.sv -----
// Block write generator: scales, clips and walks one pixel's write block.
module pbu_gen
  import pbu_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [SCALE_W-1:0]    eff_scale,
  input  logic [COORD_BITS-1:0] panel_width,
  input  logic [COORD_BITS-1:0] panel_height,
  input  logic                  job_valid,
  output logic                  job_take,
  input  logic [COORD_BITS:0]   job_lx,
  input  logic [COORD_BITS:0]   job_ly,
  input  logic [15:0]           job_color,
  output logic                  active,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y,
  output logic [15:0]           color,
  output logic                  last_of_run
);

  localparam int LW = COORD_BITS + 1;
  localparam int BW = LW + SCALE_W;

  logic [BW-1:0]         bx_calc, by_calc;
  logic [SCALE_W-1:0]    nx_calc, ny_calc;
  logic [COORD_BITS-1:0] bx, by;
  logic [SCALE_W-1:0]    nx, ny, cx, cy;
  logic [15:0]           pix;
  logic                  out_free, step, last_col, last_row, finish;

  assign bx_calc = BW'(job_lx) * BW'(eff_scale);
  assign by_calc = BW'(job_ly) * BW'(eff_scale);

  // Count the writes of one block row, and the block rows, that land on the panel.
  always_comb begin
    logic [BW-1:0] rem_x, rem_y;
    rem_x = BW'(panel_width) - bx_calc;
    rem_y = BW'(panel_height) - by_calc;
    if (bx_calc >= BW'(panel_width)) begin
      nx_calc = '0;
    end else begin
      nx_calc = (rem_x < BW'(eff_scale)) ? SCALE_W'(rem_x) : eff_scale;
    end
    if (by_calc >= BW'(panel_height)) begin
      ny_calc = '0;
    end else begin
      ny_calc = (rem_y < BW'(eff_scale)) ? SCALE_W'(rem_y) : eff_scale;
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign step     = active && out_free;
  assign last_col = (cx == nx - SCALE_W'(1));
  assign last_row = (cy == ny - SCALE_W'(1));
  assign finish   = step && last_col && last_row;
  assign job_take = job_valid && (!active || finish);

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (job_take) begin
        active <= (nx_calc != '0) && (ny_calc != '0);
      end else if (finish) begin
        active <= 1'b0;
      end
      if (out_free) begin
        out_valid <= step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      bx  <= COORD_BITS'(bx_calc);
      by  <= COORD_BITS'(by_calc);
      nx  <= nx_calc;
      ny  <= ny_calc;
      cx  <= '0;
      cy  <= '0;
      pix <= job_color;
    end else if (step) begin
      if (last_col) begin
        cx <= '0;
        cy <= cy + SCALE_W'(1);
      end else begin
        cx <= cx + SCALE_W'(1);
      end
    end
    if (step) begin
      out_x       <= bx + COORD_BITS'(cx);
      out_y       <= by + COORD_BITS'(cy);
      color       <= pix;
      last_of_run <= last_col && last_row;
    end
  end

endmodule

// ----- rtl/pixel_block_upscaler_with_clip.sv -----
// First panel write: the pixel word is registered in stage 1, taken by the write generator,
//   then registered in the output register. Throughput: one panel write per cycle unless
//   out_stall holds it; a pixel keeps the generator busy for its visible writes (4 at scale 2).
// A new pixel word is taken while the previous block is still being written.
// Reset (synchronous): scale 2, panel 720 x 1280, tile position zero, pipeline empty.
module pixel_block_upscaler_with_clip
  import pbu_pkg::*;
#(
  parameter int MAX_SCALE  = DEF_MAX_SCALE,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration write port
  input  logic                     cfg_en,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [COORD_BITS-1:0]    cfg_data,
  // pixel word channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [COORD_BITS-1:0]    tile_x,
  input  logic [COORD_BITS-1:0]    tile_y,
  input  logic [COORD_BITS-1:0]    tile_w,
  input  logic [COORD_BITS-1:0]    tile_h,
  input  logic [15:0]              pixel,
  // panel write channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [COORD_BITS-1:0]    out_x,
  output logic [COORD_BITS-1:0]    out_y,
  output logic [15:0]              color,
  output logic                     last_of_run
);

`include "pixel_block_upscaler_with_clip_assert.svh"

  logic [SCALE_BITS-1:0] scale;
  logic [COORD_BITS-1:0] panel_width;
  logic [COORD_BITS-1:0] panel_height;
  logic [SCALE_W-1:0]    eff_scale;

  logic                  job_valid;
  logic                  job_take;
  logic [COORD_BITS:0]   job_lx, job_ly;
  logic [15:0]           job_color;
  logic                  gen_active;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale        <= RST_SCALE;
      panel_width  <= COORD_BITS'(RST_PANEL_W);
      panel_height <= COORD_BITS'(RST_PANEL_H);
    end else if (cfg_en) begin
      unique case (cfg_addr)
        REG_SCALE:   scale        <= cfg_data[SCALE_BITS-1:0];
        REG_PANEL_W: panel_width  <= cfg_data;
        REG_PANEL_H: panel_height <= cfg_data;
        default:     ;
      endcase
    end
  end

  // Effective replication factor, clamped to 1..MAX_SCALE.
  assign eff_scale = clamp_scale(scale, SCALE_W'(MAX_SCALE));

  // Stage 1: hold the pixel and its logical coordinate, advance the tile position.
  pbu_pos #(
    .COORD_BITS(COORD_BITS)
  ) u_pos (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .tile_x   (tile_x),
    .tile_y   (tile_y),
    .tile_w   (tile_w),
    .tile_h   (tile_h),
    .pixel    (pixel),
    .job_take (job_take),
    .job_valid(job_valid),
    .job_lx   (job_lx),
    .job_ly   (job_ly),
    .job_color(job_color)
  );

  // Stage 2: scale, clip and walk the write block into the output register.
  pbu_gen #(
    .COORD_BITS(COORD_BITS)
  ) u_gen (
    .clk         (clk),
    .rst         (rst),
    .eff_scale   (eff_scale),
    .panel_width (panel_width),
    .panel_height(panel_height),
    .job_valid   (job_valid),
    .job_take    (job_take),
    .job_lx      (job_lx),
    .job_ly      (job_ly),
    .job_color   (job_color),
    .active      (gen_active),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_x       (out_x),
    .out_y       (out_y),
    .color       (color),
    .last_of_run (last_of_run)
  );

  // Every emitted write lies on the panel.
  `PBU_ASSERT(a_on_panel, out_valid |-> (out_x < panel_width) && (out_y < panel_height))
  // The input only stalls while a pixel waits in stage 1.
  `PBU_ASSERT(a_stall_cause, in_stall |-> job_valid)
  // A pending pixel is handed over when the generator is idle.
  `PBU_ASSERT(a_take_idle, (job_valid && !gen_active) |-> job_take)
  // Nothing leaves the block right after reset.
  `PBU_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid && !job_valid)

endmodule
